// File: hw/rtl/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

	// Byte values and bit positions of the PS/2 mouse protocol.
	localparam logic [7:0] RESET_ACK_BYTE = 8'hAA;
	localparam logic [7:0] RESET_ID_BYTE  = 8'h00;
	localparam int         X_SIGN_BIT     = 4;
	localparam int         Y_SIGN_BIT     = 5;
	localparam logic [2:0] BUTTON_MASK    = 3'h7;

	localparam int POS_W   = 16;
	localparam int DELTA_W = 9;
	localparam int BTN_W   = 3;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_ABSORBED  = 2'd0,
		STATUS_PACKET    = 2'd1,
		STATUS_RECONNECT = 2'd2
	} status_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_X_LIMIT = 1'b0,
		CFG_Y_LIMIT = 1'b1
	} cfg_index_t;

endpackage

// File: hw/rtl/ps2mt_if.sv
// ----------------------------------------------------------------------------
// ps2mt interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------

// Channel of received mouse bytes.
interface ps2mt_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Channel of result items, one for each received byte.
interface ps2mt_result_if;
	logic                                  valid;
	logic                                  ready;
	ps2mt_pkg::status_t                    status;
	logic signed [ps2mt_pkg::DELTA_W-1:0]  delta_x;
	logic signed [ps2mt_pkg::DELTA_W-1:0]  delta_y;
	logic [ps2mt_pkg::BTN_W-1:0]           buttons;
	logic [ps2mt_pkg::POS_W-1:0]           pos_x;
	logic [ps2mt_pkg::POS_W-1:0]           pos_y;
	logic [ps2mt_pkg::BTN_W-1:0]           edge_mask;

	modport source (output valid, output status, output delta_x, output delta_y,
		output buttons, output pos_x, output pos_y, output edge_mask, input ready);
	modport sink (input valid, input status, input delta_x, input delta_y,
		input buttons, input pos_x, input pos_y, input edge_mask, output ready);
endinterface

// Register write channel.
interface ps2mt_cfg_if;
	logic                           valid;
	logic                           ready;
	ps2mt_pkg::cfg_index_t          index;
	logic [ps2mt_pkg::POS_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Gathers PS/2 mouse bytes into packets and tracks a clamped position.
// ----------------------------------------------------------------------------
// Each received byte gives exactly one result item. A byte is taken into an
// input register, decoded against the tracker state in one pass of shallow
// logic and written to the result register, so one byte is accepted in every
// cycle while the result receiver does not stall. The result is held in the
// result register until the receiver takes it. The result register and the
// input register let a new byte enter while a finished result still waits.
// Positions saturate at zero and at the limit registers (a limit of zero
// means the full 16-bit range); the limits are written through the
// configuration channel, which is always ready.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker (
	input logic            clk,
	input logic            arst_n,
	ps2mt_rx_if.sink       rx,
	ps2mt_result_if.source result,
	ps2mt_cfg_if.sink      cfg
);
	import ps2mt_pkg::*;

	localparam int SUM_W = POS_W + 2;

	// Configuration registers.
	logic [POS_W-1:0] x_limit_q;
	logic [POS_W-1:0] y_limit_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Tracker state.
	logic [1:0]                byte_count_q;
	logic                      saw_ack_q;
	logic [7:0]                store_q [2];
	logic signed [DELTA_W-1:0] last_dx_q;
	logic signed [DELTA_W-1:0] last_dy_q;
	logic [BTN_W-1:0]          last_btn_q;
	logic [POS_W-1:0]          pos_x_q;
	logic [POS_W-1:0]          pos_y_q;
	logic [BTN_W-1:0]          edges_q;

	// Result stage.
	logic valid_s2;

	// Next-state values.
	logic                      advance_s1;
	logic                      reconnect;
	logic                      complete;
	status_t                   status_d;
	logic signed [DELTA_W-1:0] dx_d;
	logic signed [DELTA_W-1:0] dy_d;
	logic [BTN_W-1:0]          btn_d;
	logic [POS_W-1:0]          pos_x_d;
	logic [POS_W-1:0]          pos_y_d;
	logic [BTN_W-1:0]          edges_d;

	// Clamp a position plus a signed delta into [0, limit].
	function automatic logic [POS_W-1:0] clamp_add(
		input logic [POS_W-1:0]          pos,
		input logic signed [DELTA_W-1:0] delta,
		input logic [POS_W-1:0]          limit
	);
		logic signed [SUM_W-1:0] sum;
		logic [POS_W-1:0]        top;
		begin
			top = (limit == '0) ? {POS_W{1'b1}} : limit;
			sum = $signed({2'b00, pos}) + SUM_W'(delta);
			if (sum < 0) begin
				clamp_add = '0;
			end else if (sum > $signed({2'b00, top})) begin
				clamp_add = top;
			end else begin
				clamp_add = sum[POS_W-1:0];
			end
		end
	endfunction

	// Handshakes: the input register moves on when the result register frees.
	assign advance_s1 = valid_s1 && (!valid_s2 || result.ready);
	assign rx.ready   = !valid_s1 || advance_s1;
	assign cfg.ready  = 1'b1;

	// Decode of the byte in the input register.
	always_comb begin
		reconnect = saw_ack_q && (byte_s1 == RESET_ID_BYTE);
		complete  = !reconnect && (byte_count_q == 2'd2);
		btn_d     = last_btn_q;
		dx_d      = last_dx_q;
		dy_d      = last_dy_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		edges_d   = edges_q;
		if (reconnect) begin
			status_d = STATUS_RECONNECT;
		end else if (complete) begin
			status_d = STATUS_PACKET;
		end else begin
			status_d = STATUS_ABSORBED;
		end
		if (complete) begin
			btn_d   = store_q[0][BTN_W-1:0] & BUTTON_MASK;
			dx_d    = {store_q[0][X_SIGN_BIT], store_q[1]};
			dy_d    = {store_q[0][Y_SIGN_BIT], byte_s1};
			pos_x_d = clamp_add(pos_x_q, dx_d, x_limit_q);
			pos_y_d = clamp_add(pos_y_q, dy_d, y_limit_q);
			edges_d = edges_q | btn_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q <= '0;
			y_limit_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_X_LIMIT: x_limit_q <= cfg.data;
				CFG_Y_LIMIT: y_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Tracker state, updated as the byte moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			saw_ack_q    <= 1'b0;
			store_q[0]   <= '0;
			store_q[1]   <= '0;
			last_dx_q    <= '0;
			last_dy_q    <= '0;
			last_btn_q   <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			edges_q      <= '0;
		end else if (advance_s1) begin
			saw_ack_q <= (byte_s1 == RESET_ACK_BYTE) || reconnect;
			if (reconnect || complete) begin
				byte_count_q <= '0;
			end else begin
				store_q[byte_count_q[0]] <= byte_s1;
				byte_count_q             <= byte_count_q + 2'd1;
			end
			last_dx_q  <= dx_d;
			last_dy_q  <= dy_d;
			last_btn_q <= btn_d;
			pos_x_q    <= pos_x_d;
			pos_y_q    <= pos_y_d;
			edges_q    <= edges_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result.status    <= status_d;
			result.delta_x   <= dx_d;
			result.delta_y   <= dy_d;
			result.buttons   <= btn_d;
			result.pos_x     <= pos_x_d;
			result.pos_y     <= pos_y_d;
			result.edge_mask <= edges_d;
		end
	end

	assign result.valid = valid_s2;

endmodule

// File: tb/ps2mt_report_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_report_check
// Watches the byte, result and register channels of the packet tracker. It
// keeps its own copy of the tracker state, works out the result item due for
// every accepted byte and compares each accepted result item with the oldest
// one still waiting.
// ----------------------------------------------------------------------------
module ps2mt_report_check (
	input  logic     clk,
	input  logic     arst_n,
	ps2mt_rx_if      rx,
	ps2mt_result_if  result,
	ps2mt_cfg_if     cfg,
	output int       fail_count,
	output int       pending,
	output int       packets_seen,
	output int       reconnects_seen
);
	import ps2mt_pkg::*;

	// One result item as the tracker should report it.
	typedef struct {
		status_t                   status;
		logic signed [DELTA_W-1:0] delta_x;
		logic signed [DELTA_W-1:0] delta_y;
		logic [BTN_W-1:0]          buttons;
		logic [POS_W-1:0]          pos_x;
		logic [POS_W-1:0]          pos_y;
		logic [BTN_W-1:0]          edge_mask;
	} mouse_report_t;

	mouse_report_t report_q[$];

	// Shadow copy of the limit registers and of the tracker state.
	logic [POS_W-1:0]          x_lim;
	logic [POS_W-1:0]          y_lim;
	logic [1:0]                bytes_held;
	logic                      ack_pending;
	logic [7:0]                head_byte;
	logic [7:0]                x_byte;
	logic signed [DELTA_W-1:0] dx_held;
	logic signed [DELTA_W-1:0] dy_held;
	logic [BTN_W-1:0]          btn_held;
	logic [BTN_W-1:0]          sticky_btn;
	logic [POS_W-1:0]          cur_x;
	logic [POS_W-1:0]          cur_y;
	int                        errors;
	int                        packets;
	int                        reconnects;

	// Adds a signed delta to a position at full width, then saturates at
	// zero and at the limit (a zero limit means the full 16-bit range).
	function automatic logic [POS_W-1:0] move_clamped(input logic [POS_W-1:0] pos,
		input logic signed [DELTA_W-1:0] delta, input logic [POS_W-1:0] limit);
		int sum;
		int ceiling;
		sum = int'(pos) + int'(delta);
		ceiling = (limit == '0) ? 65535 : int'(limit);
		if (sum < 0)
			return '0;
		if (sum > ceiling)
			return POS_W'(ceiling);
		return POS_W'(sum);
	endfunction

	// Compares one field and reports a difference.
	task automatic check_field(input string field, input integer want_v, input integer got_v);
		if (want_v !== got_v) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mouse_report_t want;
		logic [7:0]    b;
		logic          reconnect;
		if (!arst_n) begin
			report_q.delete();
			x_lim       = '0;
			y_lim       = '0;
			bytes_held  = '0;
			ack_pending = 1'b0;
			head_byte   = '0;
			x_byte      = '0;
			dx_held     = '0;
			dy_held     = '0;
			btn_held    = '0;
			sticky_btn  = '0;
			cur_x       = '0;
			cur_y       = '0;
			errors      = 0;
			packets     = 0;
			reconnects  = 0;
			fail_count      <= 0;
			pending         <= 0;
			packets_seen    <= 0;
			reconnects_seen <= 0;
		end else begin
			// Register writes take effect for the bytes that follow.
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_X_LIMIT: x_lim = cfg.data;
					CFG_Y_LIMIT: y_lim = cfg.data;
					default: ;
				endcase
			end

			// Work out the result item for an accepted byte.
			if (rx.valid && rx.ready) begin
				b = rx.rx_byte;
				reconnect = 1'b0;
				want.status = STATUS_ABSORBED;
				if (ack_pending) begin
					if (b == RESET_ID_BYTE) begin
						bytes_held = '0;
						reconnect = 1'b1;
						want.status = STATUS_RECONNECT;
						reconnects++;
					end else if (b != RESET_ACK_BYTE) begin
						ack_pending = 1'b0;
					end
				end
				if (!reconnect) begin
					if (bytes_held == 2'd0) begin
						head_byte = b;
						bytes_held = 2'd1;
					end else if (bytes_held == 2'd1) begin
						x_byte = b;
						bytes_held = 2'd2;
					end else begin
						// Third byte: decode the packet and move the position.
						btn_held = head_byte[BTN_W-1:0] & BUTTON_MASK;
						dx_held = {head_byte[X_SIGN_BIT], x_byte};
						dy_held = {head_byte[Y_SIGN_BIT], b};
						cur_x = move_clamped(cur_x, dx_held, x_lim);
						cur_y = move_clamped(cur_y, dy_held, y_lim);
						sticky_btn = sticky_btn | btn_held;
						bytes_held = 2'd0;
						want.status = STATUS_PACKET;
						packets++;
					end
					// An ack byte arms the reconnect check, even at a packet end.
					if (b == RESET_ACK_BYTE)
						ack_pending = 1'b1;
				end
				want.delta_x   = dx_held;
				want.delta_y   = dy_held;
				want.buttons   = btn_held;
				want.pos_x     = cur_x;
				want.pos_y     = cur_y;
				want.edge_mask = sticky_btn;
				report_q.push_back(want);
			end

			// Compare an accepted result item with the oldest prediction.
			if (result.valid && result.ready) begin
				if (report_q.size() == 0) begin
					errors++;
					$display("%0t ns: result item with none expected, status %0d pos %0d/%0d",
						$time, result.status, result.pos_x, result.pos_y);
				end else begin
					want = report_q.pop_front();
					check_field("status", want.status, result.status);
					check_field("delta_x", want.delta_x, result.delta_x);
					check_field("delta_y", want.delta_y, result.delta_y);
					check_field("buttons", want.buttons, result.buttons);
					check_field("pos_x", want.pos_x, result.pos_x);
					check_field("pos_y", want.pos_y, result.pos_y);
					check_field("edge_mask", want.edge_mask, result.edge_mask);
				end
			end

			fail_count      <= errors;
			pending         <= report_q.size();
			packets_seen    <= packets;
			reconnects_seen <= reconnects;
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives received mouse bytes and limit register writes into the packet
// tracker: a short directed opening, a long climb up the position range,
// then random packets, reconnect sequences and noise under several limit
// settings and idling patterns. The report check judges every result.
// ----------------------------------------------------------------------------
module tb_top;
	import ps2mt_pkg::*;

	localparam int CLK_HALF_NS     = 4;
	localparam int RESET_CYCLES    = 12;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int CLIMB_PACKETS   = 100;
	localparam int BYTES_PER_SLICE = 45;
	localparam int SETTLE_CYCLES   = 6;

	logic        clk;
	logic        arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned cycle_cnt;
	int          bytes_sent;
	int          limit_writes;
	int          fail_count;
	int          pending;
	int          packets_seen;
	int          reconnects_seen;

	// Opening bytes: extremes of the deltas, every status and the reconnect
	// flag corner cases.
	logic [7:0] opening_bytes [25] = '{
		8'h08, 8'h00, 8'h00,   // packet with no motion
		8'h37, 8'h00, 8'h00,   // all buttons, -256 on both axes at zero
		8'h0F, 8'hFF, 8'hFF,   // +255 on both axes
		8'h18, 8'hFF, 8'h01,   // X -1, Y +1
		8'hAA, 8'h00,          // reconnect at a packet boundary
		8'h00,                 // flag still armed, reconnect again
		8'hAA, 8'hAA, 8'h00,   // two ack bytes, then reconnect mid-packet
		8'h2B, 8'h80, 8'hAA,   // ack byte that ends a packet
		8'h00,                 // reconnect after the packet-ending ack
		8'hAA, 8'h55, 8'h07    // 0x55 disarms the flag, packet completes
	};

	ps2mt_rx_if     rx();
	ps2mt_result_if result();
	ps2mt_cfg_if    cfg();

	ps2_mouse_packet_tracker uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.result (result),
		.cfg    (cfg)
	);

	ps2mt_report_check report_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx),
		.result          (result),
		.cfg             (cfg),
		.fail_count      (fail_count),
		.pending         (pending),
		.packets_seen    (packets_seen),
		.reconnects_seen (reconnects_seen)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// Result receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog on the whole run.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles with %0d result items outstanding", cycle_cnt, pending);
		$display("Simulation FAILED");
		$finish;
	end

	// Sends one byte, with random idle cycles ahead of it.
	task automatic send_byte(input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx.ready);
		bytes_sent++;
	endtask

	task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
		input logic [7:0] dy);
		send_byte(head);
		send_byte(dx);
		send_byte(dy);
	endtask

	// Stops sending and waits until every expected result item has arrived.
	task automatic drain();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [POS_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		limit_writes++;
	endtask

	task automatic set_limits(input logic [POS_W-1:0] x_max, input logic [POS_W-1:0] y_max);
		write_reg(CFG_X_LIMIT, x_max);
		write_reg(CFG_Y_LIMIT, y_max);
	endtask

	// Byte values biased toward the protocol codes and delta extremes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return RESET_ACK_BYTE;
			1: return RESET_ID_BYTE;
			2: return 8'hFF;
			3: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	// Limit values: no clamp, the full range, tiny, moderate or anything.
	function automatic logic [POS_W-1:0] pick_limit();
		case ($urandom_range(4))
			0: return '0;
			1: return 16'hFFFF;
			2: return POS_W'($urandom_range(1, 8));
			3: return POS_W'($urandom_range(50, 700));
			default: return POS_W'($urandom);
		endcase
	endfunction

	// Mostly whole packets with random content, some reconnect sequences
	// and some stray bytes that break the packet framing.
	task automatic run_traffic(input int n_bytes);
		int stop_at;
		int kind;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			kind = int'($urandom_range(99));
			if (kind < 70) begin
				send_packet(8'($urandom), pick_byte(), pick_byte());
			end else if (kind < 85) begin
				send_byte(RESET_ACK_BYTE);
				repeat ($urandom_range(1, 2))
					send_byte(($urandom_range(3) == 0) ? RESET_ACK_BYTE : RESET_ID_BYTE);
			end else begin
				repeat ($urandom_range(1, 2)) send_byte(pick_byte());
			end
			// Now and then the sender waits for the tracker to empty.
			if ($urandom_range(149) == 0)
				drain();
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		bytes_sent     = 0;
		limit_writes   = 0;
		rx.valid       <= 1'b0;
		rx.rx_byte     <= '0;
		cfg.valid      <= 1'b0;
		cfg.index      <= CFG_X_LIMIT;
		cfg.data       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening with the reset limits.
		foreach (opening_bytes[i])
			send_byte(opening_bytes[i]);
		drain();

		// Climb far up the unclamped range with positive deltas.
		set_limits('0, '0);
		repeat (CLIMB_PACKETS)
			send_packet(8'($urandom) & 8'hCF, 8'hFF, 8'hFF);
		drain();

		// Limits below the current position, then back to the full range.
		set_limits(16'd100, 16'd1);
		send_packet(8'h00, 8'h01, 8'h00);
		send_packet(8'h30, 8'h9C, 8'hFF);
		drain();
		set_limits(16'hFFFF, 16'hFFFF);
		send_packet(8'h07, 8'h7F, 8'h7F);
		drain();

		// Random traffic: two limit settings under each idling pattern.
		for (int slice = 0; slice < 8; slice++) begin
			case (slice / 2)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			set_limits(pick_limit(), pick_limit());
			run_traffic(BYTES_PER_SLICE);
			drain();
		end

		$display("Sent %0d bytes: %0d packets and %0d reconnects checked,", bytes_sent,
			packets_seen, reconnects_seen);
		$display("across %0d limit writes and four idling patterns.", limit_writes);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
